/* rtl/ppsc_pkg.sv */
// Shared types, constants and helper functions for the perspective screen clamp.
// Used by every module of the block but the checker; depends on nothing.
package ppsc_pkg;

   localparam int PROD_W = 53;   // one coordinate times one axis component
   localparam int CAM_W  = 55;   // camera coordinate, units of 2^-34
   localparam int OPA_W  = 56;   // ratio numerator and divisor operands
   localparam int OPB_W  = 48;   // ratio multiplier operand and result
   localparam int PIX_W  = 34;   // wide pixel coordinate
   localparam int FIX_W  = 50;   // Q.16 position before truncation
   localparam int PW     = 104;  // product and remainder width
   localparam int MUL_N  = 48;
   localparam int DIV_N  = 46;
   localparam int SQRT_N = 47;

   localparam logic [OPB_W-1:0] RAY_LIM = 48'h3FFF_FFFF_FFFF;

   localparam logic OP_RATIO = 1'b0;
   localparam logic OP_SQRT  = 1'b1;

   localparam logic [1:0] MODE_VIS    = 2'd0;
   localparam logic [1:0] MODE_WIDE   = 2'd1;
   localparam logic [1:0] MODE_NARROW = 2'd2;
   localparam logic [1:0] MODE_RADIAL = 2'd3;

   localparam logic [3:0] CSR_AXIS_RIGHT   = 4'd0;
   localparam logic [3:0] CSR_AXIS_UP      = 4'd1;
   localparam logic [3:0] CSR_AXIS_FORWARD = 4'd2;
   localparam logic [3:0] CSR_ZOOM         = 4'd3;
   localparam logic [3:0] CSR_WIDTH        = 4'd4;
   localparam logic [3:0] CSR_HEIGHT       = 4'd5;
   localparam logic [3:0] CSR_CENTER_X     = 4'd6;
   localparam logic [3:0] CSR_CENTER_Y     = 4'd7;

   localparam logic signed [14:0] MARGIN_WIDE_SIDE   = 15'sd40;
   localparam logic signed [14:0] MARGIN_WIDE_TOP    = 15'sd100;
   localparam logic signed [14:0] MARGIN_NARROW      = 15'sd20;

   // 1/5 of a pixel count: multiply by this and drop 18 bits (times four first for 4/5).
   localparam logic [15:0] RECIP_5 = 16'd52429;

   typedef struct packed {
      logic [62:0] axis_right;
      logic [62:0] axis_up;
      logic [62:0] axis_forward;
      logic [23:0] zoom;
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [11:0] center_x;
      logic [11:0] center_y;
   } cfg_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic                    in_front;
      logic signed [CAM_W-1:0] cam_x;
      logic signed [CAM_W-1:0] cam_y;
      logic [CAM_W-1:0]        depth;
   } item_type;

   typedef struct packed {
      logic                    op;
      logic signed [OPA_W-1:0] a;
      logic signed [OPB_W-1:0] b;
      logic signed [OPA_W-1:0] c;
   } arith_req_type;

   typedef struct packed {
      logic full;
      logic almost_full;
   } queue_stat_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               in_front;
      logic               on_screen;
      logic               clipped;
   } result_type;

   // Q.16 value to whole pixels, truncated toward zero.
   function automatic logic signed [PIX_W-1:0] trunc_px(input logic signed [FIX_W-1:0] v);
      logic [FIX_W-1:0] mag;
      logic [FIX_W-1:0] q;
      mag = v[FIX_W-1] ? (~v + 1'b1) : v;
      q = mag >> 16;
      trunc_px = v[FIX_W-1] ? PIX_W'(~q + 1'b1) : PIX_W'(q);
   endfunction

   function automatic logic signed [FIX_W-1:0] fix_center(input logic [11:0] c);
      fix_center = {22'b0, c, 16'b0};
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [PIX_W-1:0] v);
      if (v > 34'sd32767) begin
         sat16 = 16'sh7FFF;
      end else if (v < -34'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

endpackage

/* rtl/ppsc_front.sv */
// Front end: accepts points and turns them into camera coordinates and depth.
// Registered products, then combinational sums; uses ppsc_pkg, feeds ppsc_queue.
module ppsc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic signed [31:0]    req_point_x,
   input  logic signed [31:0]    req_point_y,
   input  logic signed [31:0]    req_point_z,
   input  ppsc_pkg::cfg_type     cfg,
   input  ppsc_pkg::queue_stat_type qstat,
   output logic                  push,
   output ppsc_pkg::item_type    item
);
   import ppsc_pkg::*;

   logic [2:0][62:0] axes;
   logic [2:0][31:0] pt;
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [PROD_W-1:0] prod_ff [9];
   logic                     s0_valid_ff;
   logic [1:0]               mode_ff;
   logic signed [CAM_W-1:0]  cam [3];
   logic [20:0]              comp;
   logic                     accept;

   assign axes = {cfg.axis_forward, cfg.axis_up, cfg.axis_right};
   assign pt   = {req_point_z, req_point_y, req_point_x};

   // Room is counted against the queue level plus the point in the product stage.
   assign req_ready = !(qstat.full || (qstat.almost_full && s0_valid_ff));
   assign accept    = req_valid && req_ready;

   always_comb begin
      comp = '0;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            comp = axes[j][21*k +: 21];
            prod_in[3*j+k] = $signed({{21{pt[k][31]}}, pt[k]}) *
                             $signed({{32{comp[20]}}, comp});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      if (accept) begin
         mode_ff <= req_mode;
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         cam[j] = CAM_W'(prod_ff[3*j]) + CAM_W'(prod_ff[3*j+1]) + CAM_W'(prod_ff[3*j+2]);
      end
   end

   assign push          = s0_valid_ff;
   assign item.mode     = mode_ff;
   assign item.in_front = !cam[2][CAM_W-1];
   assign item.cam_x    = cam[0];
   assign item.cam_y    = cam[1];
   // A depth of exactly zero counts as one unit.
   assign item.depth    = (cam[2] == '0) ? CAM_W'(1) :
                          (cam[2][CAM_W-1] ? CAM_W'(-cam[2]) : CAM_W'(cam[2]));

endmodule

/* rtl/ppsc_queue.sv */
// Short queue between the front end and the back end.
// Uses ppsc_pkg for the item type; written by ppsc_front, read by ppsc_back.
module ppsc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ppsc_pkg::item_type      wr_item,
   input  logic                    pop,
   output logic                    rd_valid,
   output ppsc_pkg::item_type      rd_item,
   output ppsc_pkg::queue_stat_type qstat
);
   import ppsc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type        mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            pop_ok;

   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem[rd_ptr_ff];
   assign pop_ok   = pop && rd_valid;

   assign qstat.full        = (count_ff == (AW+1)'(DEPTH));
   assign qstat.almost_full = (count_ff == (AW+1)'(DEPTH - 1));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

/* rtl/ppsc_arith.sv */
// Shared serial arithmetic unit: saturated trunc(a*b/c) and floor(sqrt(a^2+b^2)).
// Shift-add multiply, restoring divide and digit square root; uses ppsc_pkg.
module ppsc_arith (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  ppsc_pkg::arith_req_type     req,
   output logic                        done,
   output logic signed [ppsc_pkg::OPB_W-1:0] result
);
   import ppsc_pkg::*;

   localparam logic [2:0] A_IDLE = 3'd0;
   localparam logic [2:0] A_MUL  = 3'd1;
   localparam logic [2:0] A_CHK  = 3'd2;
   localparam logic [2:0] A_DIV  = 3'd3;
   localparam logic [2:0] A_SQRT = 3'd4;
   localparam logic [2:0] A_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              op_ff, op_in;
   logic              neg_ff, neg_in;
   logic              second_ff, second_in;
   logic [PW-1:0]     mcand_ff, mcand_in;
   logic [OPB_W-1:0]  mplier_ff, mplier_in;
   logic [OPA_W-1:0]  dval_ff, dval_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic [PW-1:0]     rem_ff, rem_in;
   logic [PW-1:0]     dsh_ff, dsh_in;
   logic [OPB_W-1:0]  q_ff, q_in;

   logic [OPA_W-1:0]  a_mag, c_mag;
   logic [OPB_W-1:0]  b_mag;
   logic [PW-1:0]     sum, dlim, remt, trial;

   assign a_mag = req.a[OPA_W-1] ? OPA_W'(-req.a) : OPA_W'(req.a);
   assign b_mag = req.b[OPB_W-1] ? OPB_W'(-req.b) : OPB_W'(req.b);
   assign c_mag = req.c[OPA_W-1] ? OPA_W'(-req.c) : OPA_W'(req.c);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      neg_in    = neg_ff;
      second_in = second_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      dval_in   = dval_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      q_in      = q_ff;
      sum       = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
      dlim      = {2'b0, dval_ff, 46'b0};
      remt      = {rem_ff[PW-3:0], acc_ff[93:92]};
      trial     = {54'b0, q_ff, 2'b01};
      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               op_in     = req.op;
               neg_in    = req.a[OPA_W-1] ^ req.b[OPB_W-1] ^ req.c[OPA_W-1];
               mcand_in  = PW'(a_mag);
               mplier_in = (req.op == OP_SQRT) ? a_mag[OPB_W-1:0] : b_mag;
               dval_in   = (req.op == OP_SQRT) ? OPA_W'(b_mag) : c_mag;
               acc_in    = '0;
               cnt_in    = '0;
               second_in = 1'b0;
               state_in  = A_MUL;
            end
         end
         A_MUL: begin
            acc_in    = sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == 6'(MUL_N - 1)) begin
               cnt_in = '0;
               if (op_ff == OP_RATIO) begin
                  state_in = A_CHK;
               end else if (!second_ff) begin
                  // Second square accumulates onto the first.
                  mcand_in  = PW'(dval_ff);
                  mplier_in = dval_ff[OPB_W-1:0];
                  second_in = 1'b1;
               end else begin
                  rem_in   = '0;
                  q_in     = '0;
                  state_in = A_SQRT;
               end
            end
         end
         A_CHK: begin
            rem_in = acc_ff;
            dsh_in = {3'b0, dval_ff, 45'b0};
            cnt_in = '0;
            q_in   = '0;
            if (acc_ff == '0) begin
               state_in = A_DONE;
            end else if (acc_ff >= dlim) begin
               // Covers a zero divisor as well as a quotient too large.
               q_in     = RAY_LIM;
               state_in = A_DONE;
            end else begin
               state_in = A_DIV;
            end
         end
         A_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[OPB_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[OPB_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(DIV_N - 1)) begin
               state_in = A_DONE;
            end
         end
         A_SQRT: begin
            if (remt >= trial) begin
               rem_in = remt - trial;
               q_in   = {q_ff[OPB_W-2:0], 1'b1};
            end else begin
               rem_in = remt;
               q_in   = {q_ff[OPB_W-2:0], 1'b0};
            end
            acc_in = acc_ff << 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(SQRT_N - 1)) begin
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      second_ff <= second_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      dval_ff   <= dval_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      q_ff      <= q_in;
   end

   assign done   = (state_ff == A_DONE);
   assign result = (op_ff == OP_RATIO && neg_ff) ? OPB_W'(-q_ff) : q_ff;

endmodule

/* rtl/ppsc_back.sv */
// Back end: projection, visibility, edge clip and radial clamp for one point.
// A sequencer over ppsc_arith with an output register; uses ppsc_pkg.
module ppsc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ppsc_pkg::cfg_type           cfg,
   input  logic                        q_valid,
   input  ppsc_pkg::item_type          q_item,
   output logic                        q_pop,
   output logic                        ar_start,
   output ppsc_pkg::arith_req_type     ar_req,
   input  logic                        ar_done,
   input  logic signed [ppsc_pkg::OPB_W-1:0] ar_result,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ppsc_pkg::result_type        rsp
);
   import ppsc_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DX   = 4'd1;
   localparam logic [3:0] S_DY   = 4'd2;
   localparam logic [3:0] S_PROJ = 4'd3;
   localparam logic [3:0] S_MODE = 4'd4;
   localparam logic [3:0] S_EDGE = 4'd5;
   localparam logic [3:0] S_RSQ  = 4'd6;
   localparam logic [3:0] S_RCMP = 4'd7;
   localparam logic [3:0] S_RX   = 4'd8;
   localparam logic [3:0] S_RY   = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   localparam logic [1:0] EDGE_LEFT   = 2'd0;
   localparam logic [1:0] EDGE_RIGHT  = 2'd1;
   localparam logic [1:0] EDGE_TOP    = 2'd2;
   localparam logic [1:0] EDGE_BOTTOM = 2'd3;

   logic [3:0]              state_ff, state_in;
   logic                    pend_ff, pend_in;
   logic [1:0]              edge_ff, edge_in;
   item_type                item_ff, item_in;
   logic signed [OPB_W-1:0] dx_ff, dx_in, dy_ff, dy_in, t_ff, t_in;
   logic signed [PIX_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic                    vis_ff, vis_in, hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;
   logic [36:0]             k_ff;
   logic [11:0]             lim_ff;
   logic [29:0]             lim_prod;

   logic signed [14:0]      w15, h15, ml, mr, mt, mb, ma;
   logic signed [PIX_W-1:0] w34, h34;
   logic [11:0]             cen;
   logic signed [15:0]      diff;
   logic signed [31:0]      diff_fix;
   logic                    edge_cond, inner, wide, arith_state;
   logic signed [PIX_W-1:0] new_px;

   assign lim_prod = 30'({cfg.center_y, 2'b0}) * 30'(RECIP_5);

   always_ff @(posedge clock) begin
      k_ff   <= 37'(cfg.zoom) * 37'(cfg.screen_height);
      lim_ff <= lim_prod[29:18];
   end

   // Margin rectangle for the current mode.
   always_comb begin
      w15  = 15'(cfg.screen_width);
      h15  = 15'(cfg.screen_height);
      w34  = PIX_W'(cfg.screen_width);
      h34  = PIX_W'(cfg.screen_height);
      wide = (item_ff.mode == MODE_WIDE);
      ml   = wide ? MARGIN_WIDE_SIDE : MARGIN_NARROW;
      mr   = w15 - (wide ? MARGIN_WIDE_SIDE : MARGIN_NARROW);
      mt   = wide ? MARGIN_WIDE_TOP : MARGIN_NARROW;
      mb   = h15 - MARGIN_NARROW;
      unique case (edge_ff)
         EDGE_LEFT: begin
            ma = ml;
            edge_cond = (sx_ff < PIX_W'(ml));
         end
         EDGE_RIGHT: begin
            ma = mr;
            edge_cond = (sx_ff > PIX_W'(mr));
         end
         EDGE_TOP: begin
            ma = mt;
            edge_cond = (sy_ff < PIX_W'(mt));
         end
         default: begin
            ma = mb;
            edge_cond = (sy_ff > PIX_W'(mb));
         end
      endcase
      cen      = edge_ff[1] ? cfg.center_x : cfg.center_y;
      diff     = 16'(ma) - $signed({4'b0, edge_ff[1] ? cfg.center_y : cfg.center_x});
      diff_fix = {diff, 16'b0};
      inner    = (sx_ff > PIX_W'(MARGIN_NARROW)) && (sx_ff < w34 - PIX_W'(MARGIN_NARROW)) &&
                 (sy_ff > PIX_W'(MARGIN_NARROW)) && (sy_ff < h34 - PIX_W'(MARGIN_NARROW));
      new_px   = trunc_px(FIX_W'(ar_result) + fix_center(cen));
   end

   // Operands for whichever step is running.
   always_comb begin
      ar_req.op = OP_RATIO;
      ar_req.a  = OPA_W'(item_ff.cam_x);
      ar_req.b  = {11'b0, k_ff};
      ar_req.c  = OPA_W'({1'b0, item_ff.depth});
      unique case (state_ff) inside
         S_DY: begin
            ar_req.a = OPA_W'(item_ff.cam_y);
         end
         S_EDGE: begin
            ar_req.a = OPA_W'(diff_fix);
            ar_req.b = edge_ff[1] ? dx_ff : dy_ff;
            ar_req.c = OPA_W'(edge_ff[1] ? dy_ff : dx_ff);
         end
         S_RSQ: begin
            ar_req.op = OP_SQRT;
            ar_req.a  = OPA_W'(dx_ff);
            ar_req.b  = dy_ff;
            ar_req.c  = '0;
         end
         S_RX, S_RY: begin
            ar_req.a = OPA_W'(state_ff == S_RX ? dx_ff : dy_ff);
            ar_req.b = {20'b0, lim_ff, 16'b0};
            ar_req.c = OPA_W'(t_ff);
         end
         default: begin
         end
      endcase
   end

   assign arith_state = (state_ff == S_DX) || (state_ff == S_DY) || (state_ff == S_RSQ) ||
                        (state_ff == S_RX) || (state_ff == S_RY);
   assign ar_start    = !pend_ff && (arith_state || (state_ff == S_EDGE && edge_cond));
   assign q_pop       = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      edge_in      = edge_ff;
      item_in      = item_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      t_in         = t_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      vis_in       = vis_ff;
      hit_in       = hit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ar_start) begin
         pend_in = 1'b1;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               vis_in   = 1'b0;
               hit_in   = 1'b0;
               state_in = S_DX;
            end
         end
         S_DX: begin
            if (pend_ff && ar_done) begin
               dx_in    = ar_result;
               pend_in  = 1'b0;
               state_in = S_DY;
            end
         end
         S_DY: begin
            if (pend_ff && ar_done) begin
               dy_in    = OPB_W'(-ar_result);
               pend_in  = 1'b0;
               state_in = S_PROJ;
            end
         end
         S_PROJ: begin
            sx_in    = trunc_px(FIX_W'(dx_ff) + fix_center(cfg.center_x));
            sy_in    = trunc_px(FIX_W'(dy_ff) + fix_center(cfg.center_y));
            state_in = S_MODE;
         end
         S_MODE: begin
            edge_in = EDGE_LEFT;
            unique case (item_ff.mode)
               MODE_VIS: begin
                  vis_in   = item_ff.in_front && !sx_ff[PIX_W-1] && (sx_ff < w34) &&
                             !sy_ff[PIX_W-1] && (sy_ff < h34);
                  state_in = S_OUT;
               end
               MODE_WIDE: begin
                  state_in = S_EDGE;
               end
               MODE_NARROW: begin
                  state_in = item_ff.in_front ? S_EDGE : S_OUT;
               end
               default: begin
                  state_in = inner ? S_OUT : S_RSQ;
               end
            endcase
         end
         S_EDGE: begin
            // Each edge test sees the coordinates left by the one before it.
            if ((!pend_ff && !edge_cond) || (pend_ff && ar_done)) begin
               if (pend_ff) begin
                  pend_in = 1'b0;
                  hit_in  = 1'b1;
                  if (edge_ff[1]) begin
                     sx_in = new_px;
                     sy_in = PIX_W'(ma);
                  end else begin
                     sx_in = PIX_W'(ma);
                     sy_in = new_px;
                  end
               end
               if (edge_ff == EDGE_BOTTOM) begin
                  state_in = S_OUT;
               end else begin
                  edge_in = edge_ff + 1'b1;
               end
            end
         end
         S_RSQ: begin
            hit_in = 1'b1;
            if (pend_ff && ar_done) begin
               t_in     = ar_result;
               pend_in  = 1'b0;
               state_in = S_RCMP;
            end
         end
         S_RCMP: begin
            state_in = (t_ff > $signed({20'b0, lim_ff, 16'b0})) ? S_RX : S_OUT;
         end
         S_RX: begin
            if (pend_ff && ar_done) begin
               sx_in    = trunc_px(FIX_W'(ar_result) + fix_center(cfg.center_x));
               pend_in  = 1'b0;
               state_in = S_RY;
            end
         end
         S_RY: begin
            if (pend_ff && ar_done) begin
               sy_in    = trunc_px(FIX_W'(ar_result) + fix_center(cfg.center_y));
               pend_in  = 1'b0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.screen_x  = sat16(sx_ff);
               rsp_in.screen_y  = sat16(sy_ff);
               rsp_in.in_front  = item_ff.in_front;
               rsp_in.on_screen = vis_ff;
               rsp_in.clipped   = hit_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      edge_ff <= edge_in;
      item_ff <= item_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      t_ff    <= t_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      vis_ff  <= vis_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/perspective_project_screen_clamp_core.sv */
// Top level of the perspective screen clamp: configuration registers and wiring.
// Instantiates ppsc_front, ppsc_queue, ppsc_arith and ppsc_back; uses ppsc_pkg.

// Points enter the front end at up to one beat per cycle while the queue has room,
// are turned into camera coordinates through a registered product stage and wait
// in a queue of QUEUE_DEPTH entries. The back end works on one point at a time on
// a single serial multiply/divide/square-root unit, which sets the throughput. Each
// point takes two ratios for the projection; mode 1, and mode 2 in front of the
// camera, add one ratio per clipped edge, and mode 3 outside the inner margin adds
// a square root and, when the ray is clamped, two more ratios. The result sits in an
// output register, so the back end starts the next point while a result waits to be taken.
module perspective_project_screen_clamp_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_y,
   output logic               rsp_in_front,
   output logic               rsp_on_screen,
   output logic               rsp_clipped,
   input  logic               csr_write_enable,
   input  logic [3:0]         csr_index,
   input  logic [62:0]        csr_write_data
);
   import ppsc_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   queue_stat_type        qstat;
   item_type              f_item, q_item;
   logic                  push, q_valid, q_pop;
   logic                  ar_start, ar_done;
   arith_req_type         ar_req;
   logic signed [OPB_W-1:0] ar_result;
   result_type            rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_AXIS_RIGHT:   cfg_in.axis_right    = csr_write_data;
            CSR_AXIS_UP:      cfg_in.axis_up       = csr_write_data;
            CSR_AXIS_FORWARD: cfg_in.axis_forward  = csr_write_data;
            CSR_ZOOM:         cfg_in.zoom          = csr_write_data[23:0];
            CSR_WIDTH:        cfg_in.screen_width  = csr_write_data[12:0];
            CSR_HEIGHT:       cfg_in.screen_height = csr_write_data[12:0];
            CSR_CENTER_X:     cfg_in.center_x      = csr_write_data[11:0];
            CSR_CENTER_Y:     cfg_in.center_y      = csr_write_data[11:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_right    <= '0;
         cfg_ff.axis_up       <= '0;
         cfg_ff.axis_forward  <= '0;
         cfg_ff.zoom          <= 24'd65536;
         cfg_ff.screen_width  <= 13'd640;
         cfg_ff.screen_height <= 13'd480;
         cfg_ff.center_x      <= 12'd320;
         cfg_ff.center_y      <= 12'd240;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .cfg         (cfg_ff),
      .qstat       (qstat),
      .push        (push),
      .item        (f_item)
   );

   ppsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_item  (f_item),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rd_item  (q_item),
      .qstat    (qstat)
   );

   ppsc_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (ar_start),
      .req    (ar_req),
      .done   (ar_done),
      .result (ar_result)
   );

   ppsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .ar_start  (ar_start),
      .ar_req    (ar_req),
      .ar_done   (ar_done),
      .ar_result (ar_result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_screen_x  = rsp.screen_x;
   assign rsp_screen_y  = rsp.screen_y;
   assign rsp_in_front  = rsp.in_front;
   assign rsp_on_screen = rsp.on_screen;
   assign rsp_clipped   = rsp.clipped;

endmodule

/* rtl/ppsc_checker.sv */
// Port-level checks for the perspective screen clamp, bound to the top level.
// Sees only the ports of perspective_project_screen_clamp_core.
module ppsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_screen_x,
   input logic signed [15:0] rsp_screen_y,
   input logic               rsp_in_front,
   input logic               rsp_on_screen,
   input logic               rsp_clipped
);

   // No result can be pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x) && $stable(rsp_screen_y))
      else $error("stalled result beat changed");

   // A visible point is in front of the camera and was never clamped.
   a_vis_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_on_screen |-> rsp_in_front && !rsp_clipped)
      else $error("visible point behind camera or clamped");

   // A visible point lies inside the screen, so its coordinates are not negative.
   a_vis_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_on_screen |-> !rsp_screen_x[15] && !rsp_screen_y[15])
      else $error("visible point with negative coordinate");

   // Input ready is always a known level when a beat is taken.
   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !$isunknown(req_ready))
      else $error("input ready unknown at accept");

endmodule

bind perspective_project_screen_clamp_core ppsc_checker u_ppsc_checker (.*);

/* test/perspective_project_screen_clamp_core_tb.sv */
// Self-checking testbench for perspective_project_screen_clamp_core.
// Needs ppsc_pkg and the block's RTL; it predicts every result and compares each beat.
module perspective_project_screen_clamp_core_tb;
   import ppsc_pkg::*;

   localparam int     ONE        = 65536;
   localparam longint MAX_OFFSET = 64'h3FFF_FFFF_FFFF;
   localparam longint CYCLE_CAP  = 8_000_000;
   localparam int     AXIS_ONE   = 1 << 18;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_VIS;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic               rsp_in_front;
   logic               rsp_on_screen;
   logic               rsp_clipped;
   logic               csr_write_enable = 1'b0;
   logic [3:0]         csr_index = CSR_AXIS_RIGHT;
   logic [62:0]        csr_write_data = '0;

   perspective_project_screen_clamp_core u_top (.*);

   // Copy of the configuration as the block should hold it.
   logic [62:0] cam_right, cam_up, cam_fwd;
   longint      zoom_q16, scr_w, scr_h, ctr_x, ctr_y;

   result_type  pending_px[$];
   int          mismatches = 0;
   int          beats_sent = 0;
   int          beats_checked = 0;
   int          clip_count = 0;
   int          phases = 0;
   longint      cycles = 0;
   bit          idling = 1'b1;
   int          stall_left = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_px.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side back-pressure in random bursts while idling is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch on %s at beat %0d: got %0d, expected %0d", what, beats_checked,
               got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_px.size() == 0) begin
            report("unexpected beat", 1, 0);
         end else begin
            want = pending_px.pop_front();
            if (rsp_screen_x !== want.screen_x) report("screen_x", rsp_screen_x, want.screen_x);
            if (rsp_screen_y !== want.screen_y) report("screen_y", rsp_screen_y, want.screen_y);
            if (rsp_in_front !== want.in_front) report("in_front", rsp_in_front, want.in_front);
            if (rsp_on_screen !== want.on_screen)
               report("on_screen", rsp_on_screen, want.on_screen);
            if (rsp_clipped !== want.clipped) report("clipped", rsp_clipped, want.clipped);
            if (want.clipped) clip_count++;
         end
         beats_checked++;
      end
   end

   // trunc(a*b/c), magnitude saturated to MAX_OFFSET.
   function automatic longint scaled_ratio(longint a, longint b, longint c);
      logic [63:0]  ma, mb, mc;
      logic [127:0] prod, quot;
      longint       q;
      bit           neg;
      neg = (a < 0) != (b < 0);
      if (c < 0) neg = !neg;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      mc = c < 0 ? -c : c;
      prod = {64'b0, ma} * {64'b0, mb};
      if (mc == 0) begin
         q = prod != 0 ? MAX_OFFSET : 0;
      end else begin
         quot = prod / {64'b0, mc};
         q = quot > MAX_OFFSET ? MAX_OFFSET : longint'(quot[63:0]);
      end
      return neg ? -q : q;
   endfunction

   function automatic longint root_floor(logic [127:0] s);
      logic [127:0] r, c;
      r = 0;
      for (int i = 46; i >= 0; i--) begin
         c = r | (128'd1 << i);
         if (c * c <= s) r = c;
      end
      return longint'(r[63:0]);
   endfunction

   function automatic longint axis_dot(logic [62:0] ax, longint px, longint py, longint pz);
      logic signed [20:0] ex, ey, ez;
      ex = ax[20:0];
      ey = ax[41:21];
      ez = ax[62:42];
      return px * longint'(ex) + py * longint'(ey) + pz * longint'(ez);
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Margin clip; each test sees the coordinates left by the one before.
   function automatic void clip_to_margins(inout longint sx, inout longint sy, input longint dx,
                                           input longint dy, input longint l, input longint r,
                                           input longint t, input longint b, inout bit hit);
      if (sx < l) begin
         sx = l; sy = (ctr_y * ONE + scaled_ratio((l - ctr_x) * ONE, dy, dx)) / ONE; hit = 1;
      end
      if (sx > r) begin
         sx = r; sy = (ctr_y * ONE + scaled_ratio((r - ctr_x) * ONE, dy, dx)) / ONE; hit = 1;
      end
      if (sy < t) begin
         sx = (ctr_x * ONE + scaled_ratio((t - ctr_y) * ONE, dx, dy)) / ONE; sy = t; hit = 1;
      end
      if (sy > b) begin
         sx = (ctr_x * ONE + scaled_ratio((b - ctr_y) * ONE, dx, dy)) / ONE; sy = b; hit = 1;
      end
   endfunction

   function automatic result_type project_point(logic [1:0] mode, int px, int py, int pz);
      result_type   res;
      longint       cam_x, cam_y, cam_z, depth, gain, dx, dy, sx, sy, t, lim;
      logic [127:0] sq;
      bit           front, vis, hit;
      cam_x = axis_dot(cam_right, px, py, pz);
      cam_y = axis_dot(cam_up, px, py, pz);
      cam_z = axis_dot(cam_fwd, px, py, pz);
      front = cam_z >= 0;
      depth = cam_z == 0 ? 1 : (cam_z < 0 ? -cam_z : cam_z);
      gain = zoom_q16 * scr_h;
      dx = scaled_ratio(cam_x, gain, depth);
      dy = -scaled_ratio(cam_y, gain, depth);
      sx = (ctr_x * ONE + dx) / ONE;
      sy = (ctr_y * ONE + dy) / ONE;
      vis = 0;
      hit = 0;
      case (mode)
         MODE_VIS: begin
            vis = front && sx >= 0 && sx < scr_w && sy >= 0 && sy < scr_h;
         end
         MODE_WIDE: begin
            clip_to_margins(sx, sy, dx, dy, 40, scr_w - 40, 100, scr_h - 20, hit);
         end
         MODE_NARROW: begin
            if (front) clip_to_margins(sx, sy, dx, dy, 20, scr_w - 20, 20, scr_h - 20, hit);
         end
         default: begin
            if (!(sx > 20 && sx < scr_w - 20 && sy > 20 && sy < scr_h - 20)) begin
               sq = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
                  + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy);
               t = root_floor(sq);
               lim = (ctr_y * 80 / 100) * ONE;
               if (t > lim) begin
                  sx = (ctr_x * ONE + scaled_ratio(dx, lim, t)) / ONE;
                  sy = (ctr_y * ONE + scaled_ratio(dy, lim, t)) / ONE;
               end
               hit = 1;
            end
         end
      endcase
      res.screen_x = clamp16(sx);
      res.screen_y = clamp16(sy);
      res.in_front = front;
      res.on_screen = vis;
      res.clipped = hit;
      return res;
   endfunction

   // Register write; the caller makes sure the block is idle.
   task automatic write_reg(logic [3:0] idx, logic [62:0] data);
      case (idx)
         CSR_AXIS_RIGHT:   cam_right = data;
         CSR_AXIS_UP:      cam_up = data;
         CSR_AXIS_FORWARD: cam_fwd = data;
         CSR_ZOOM:         zoom_q16 = data[23:0];
         CSR_WIDTH:        scr_w = data[12:0];
         CSR_HEIGHT:       scr_h = data[12:0];
         CSR_CENTER_X:     ctr_x = data[11:0];
         CSR_CENTER_Y:     ctr_y = data[11:0];
         default: ;
      endcase
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [62:0] pack_axis(int ax, int ay, int az);
      return {az[20:0], ay[20:0], ax[20:0]};
   endfunction

   task automatic set_camera(logic [62:0] r, logic [62:0] u, logic [62:0] f);
      write_reg(CSR_AXIS_RIGHT, r);
      write_reg(CSR_AXIS_UP, u);
      write_reg(CSR_AXIS_FORWARD, f);
   endtask

   task automatic set_screen(longint zm, longint w, longint h, longint cx, longint cy);
      write_reg(CSR_ZOOM, 63'(zm));
      write_reg(CSR_WIDTH, 63'(w));
      write_reg(CSR_HEIGHT, 63'(h));
      write_reg(CSR_CENTER_X, 63'(cx));
      write_reg(CSR_CENTER_Y, 63'(cy));
      phases++;
   endtask

   // Called just after the clock rises; returns on the edge that takes the beat.
   task automatic send_point(logic [1:0] mode, int px, int py, int pz);
      int gap;
      gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_px.push_back(project_point(mode, px, py, pz));
      req_valid <= 1'b1;
      req_mode <= mode;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
   endtask

   function automatic int random_coord(bit tame);
      int v;
      if ($urandom_range(0, 9) == 0) return 0;
      v = $urandom;
      return tame ? (v >>> $urandom_range(8, 14)) : (v >>> $urandom_range(0, 31));
   endfunction

   function automatic int random_axis_comp();
      int v;
      v = $urandom;
      return v >>> $urandom_range(11, 24);
   endfunction

   task automatic random_points(int count);
      bit tame;
      int z;
      repeat (count) begin
         tame = $urandom_range(0, 4) != 0;
         z = random_coord(tame);
         // Mostly points in front of the camera, so the projection lands near the screen.
         if (tame && $urandom_range(0, 5) != 0) z = (z < 0 ? -z : z) + ONE;
         send_point(2'($urandom_range(0, 3)), random_coord(tame), random_coord(tame),
                    tame ? z : int'($urandom));
      end
   endtask

   task automatic test_directed();
      set_camera(pack_axis(AXIS_ONE, 0, 0), pack_axis(0, AXIS_ONE, 0),
                 pack_axis(0, 0, AXIS_ONE));
      set_screen(65536, 640, 480, 320, 240);
      for (int m = 0; m < 4; m++) send_point(2'(m), 0, 0, ONE);
      send_point(MODE_VIS, ONE, 0, 0);           // zero depth
      send_point(MODE_WIDE, ONE, ONE, 0);
      send_point(MODE_NARROW, ONE / 5, 0, -ONE); // behind the camera
      send_point(MODE_WIDE, ONE / 5, 0, -ONE);
      send_point(MODE_WIDE, -ONE, 0, 2 * ONE);
      send_point(MODE_NARROW, ONE, 0, 2 * ONE);
      send_point(MODE_WIDE, 0, ONE, 2 * ONE);
      send_point(MODE_NARROW, 0, -ONE, 2 * ONE);
      send_point(MODE_WIDE, -3 * ONE, 3 * ONE, 2 * ONE);
      send_point(MODE_RADIAL, 5 * ONE, 5 * ONE, ONE);
      send_point(MODE_RADIAL, ONE * 3 / 5, 0, ONE);
      send_point(MODE_VIS, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_point(MODE_WIDE, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_point(MODE_NARROW, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
      send_point(MODE_RADIAL, 32'sh8000_0000, 32'sh8000_0000, -1);
      send_point(MODE_VIS, -1, -1, -1);
      drain();
   endtask

   task automatic test_screen_extremes();
      // One-pixel screen and center zero: a zero ray component meets the left margin.
      set_screen(0, 1, 1, 0, 0);
      random_points(60);
      drain();
      set_screen(65536, 1, 1, 0, 0);
      for (int m = 0; m < 4; m++) send_point(2'(m), 0, ONE, ONE);
      random_points(60);
      drain();
      set_screen(24'hFFFFFF, 8191, 8191, 4095, 4095);
      random_points(80);
      drain();
      set_screen(24'hFFFFFF, 0, 0, 4095, 0);
      random_points(40);
      drain();
      set_camera({63{1'b1}}, pack_axis(-(1 << 20), -(1 << 20), -(1 << 20)),
                 pack_axis((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1));
      set_screen(65536, 4096, 4096, 2048, 2048);
      random_points(60);
      drain();
   endtask

   task automatic test_random_cameras(int rounds, int per_round);
      repeat (rounds) begin
         set_camera(pack_axis(random_axis_comp(), random_axis_comp(), random_axis_comp()),
                    pack_axis(random_axis_comp(), random_axis_comp(), random_axis_comp()),
                    pack_axis(random_axis_comp(), random_axis_comp(), AXIS_ONE +
                              random_axis_comp()));
         set_screen($urandom_range(0, 1 << 18), $urandom_range(1, 4096),
                    $urandom_range(1, 4096), $urandom_range(0, 4095), $urandom_range(0, 4095));
         random_points(per_round);
         drain();
      end
   endtask

   task automatic test_hold_off();
      repeat (5) begin
         random_points(20);
         // Let the block run completely dry before the next batch.
         drain();
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_screen_extremes();
      test_hold_off();
      test_random_cameras(14, 80);
      idling = 1'b0;
      test_random_cameras(2, 120);
      drain();
      repeat (1000) @(posedge clock);
      $display("%0d points sent, %0d results checked, %0d clipped, %0d screen settings",
               beats_sent, beats_checked, clip_count, phases);
      if (mismatches == 0 && pending_px.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
